// ===== rtl/core/lla_pkg.sv =====
`default_nettype none
package lla_pkg;

  localparam int GRID_WIDTH  = 1024;
  localparam int GRID_HEIGHT = 1024;

  localparam int COL_W  = $clog2(GRID_WIDTH);
  localparam int ROW_W  = $clog2(GRID_HEIGHT);
  localparam int IDX_W  = 10;
  localparam int MASK_W = 9;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = CFG_IDX_W'(1);

  localparam logic [MASK_W-1:0] BIRTH_RESET   = MASK_W'(8);
  localparam logic [MASK_W-1:0] SURVIVE_RESET = MASK_W'(12);

  typedef struct packed {
    logic [MASK_W-1:0] window;
    logic [MASK_W-1:0] birth_mask;
    logic [MASK_W-1:0] survive_mask;
  } rule_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/lla_ram.sv =====
`default_nettype none
module lla_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lla_rule.sv =====
`default_nettype none
module lla_rule (
  input  wire lla_pkg::rule_req_t req,
  output logic                    next_alive
);

  logic [3:0] count;
  logic       center;

  always_comb begin
    count = 4'd0;
    for (int i = 0; i < lla_pkg::MASK_W; i++) begin
      if (i != 4) begin
        count = count + 4'(req.window[i]);
      end
    end
  end

  assign center     = req.window[4];
  assign next_alive = center ? req.survive_mask[count] : req.birth_mask[count];

endmodule
`default_nettype wire

// ===== rtl/core/life_like_automaton_generation.sv =====
`default_nettype none
// One generation of a life-like automaton over a raster cell stream.
// Cells past the first two rows and columns load a result into the output
// register on leaving stage 1. Throughput: one cell per cycle unless stalled;
// set by the line store RAM's one read and one write port, read at accept and
// written back as the cell leaves stage 1. Reset: counters, window and
// handshakes clear, masks return to B3/S23; the line store is not cleared.
module life_like_automaton_generation (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,   // [0] cell_alive
  input  wire logic                             s_tuser,   // [0] frame_start
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [23:0]                      m_tdata,   // [9:0] row_index,
                                                           // [19:10] col_index,
                                                           // [20] next_alive
  output logic                                  m_tlast,   // last_of_frame
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lla_pkg::MASK_W-1:0]       cfg_data
);

  localparam int COL_W = lla_pkg::COL_W;
  localparam int ROW_W = lla_pkg::ROW_W;
  localparam int IDX_W = lla_pkg::IDX_W;

  logic [lla_pkg::MASK_W-1:0] birth_mask;
  logic [lla_pkg::MASK_W-1:0] survive_mask;

  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             accept;

  logic             s1_valid;
  logic             s1_cell;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_emit;
  logic             s1_advance;
  logic             fwd_valid;
  logic [1:0]       fwd_data;
  logic             fwd_hit;

  logic [1:0]       ram_rdata;
  logic [1:0]       lines;
  logic [1:0]       ram_wdata;
  logic [8:0]       window;
  logic [8:0]       window_next;

  lla_pkg::rule_req_t rule_req;
  logic               rule_next;

  logic             out_load;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic             out_alive;
  logic             out_last;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= lla_pkg::BIRTH_RESET;
      survive_mask <= lla_pkg::SURVIVE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lla_pkg::REG_BIRTH:   birth_mask   <= cfg_data;
        lla_pkg::REG_SURVIVE: survive_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: position and line store read
  assign s_tready = !s1_valid || s1_advance;
  assign accept   = s_tvalid && s_tready;
  assign col_cur  = s_tuser ? '0 : col_cnt;
  assign row_cur  = s_tuser ? '0 : row_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_cur == COL_W'(lla_pkg::GRID_WIDTH - 1)) begin
        col_cnt <= '0;
        row_cnt <= (row_cur == ROW_W'(lla_pkg::GRID_HEIGHT - 1)) ? '0 : row_cur + 1'b1;
      end else begin
        col_cnt <= col_cur + 1'b1;
        row_cnt <= row_cur;
      end
    end
  end

  // write of the item leaving stage 1 lands on the address read now
  assign fwd_hit = s1_valid && s1_advance && (s1_col == col_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (accept) begin
      s1_valid  <= 1'b1;
      fwd_valid <= fwd_hit;
    end else if (s1_advance) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell  <= s_tdata[0];
      s1_col   <= col_cur;
      s1_row   <= row_cur;
      fwd_data <= ram_wdata;
    end
  end

  lla_ram #(
    .WIDTH (2),
    .DEPTH (lla_pkg::GRID_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_valid && s1_advance),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  // stage 1: window update, rule, write back; lines[0] upper, lines[1] middle
  assign lines       = fwd_valid ? fwd_data : ram_rdata;
  assign ram_wdata   = {s1_cell, lines[1]};
  assign window_next = {s1_cell, lines[1], lines[0], window[8:3]};
  assign s1_emit     = (s1_row >= ROW_W'(2)) && (s1_col >= COL_W'(2));
  assign s1_advance  = s1_valid && (!s1_emit || !m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_advance) begin
      window <= window_next;
    end
  end

  assign rule_req.window       = window_next;
  assign rule_req.birth_mask   = birth_mask;
  assign rule_req.survive_mask = survive_mask;

  lla_rule u_rule (
    .req        (rule_req),
    .next_alive (rule_next)
  );

  // output register
  assign out_load = s1_advance && s1_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row   <= IDX_W'(32'(s1_row) - 32'd1);
      out_col   <= IDX_W'(32'(s1_col) - 32'd1);
      out_alive <= rule_next;
      out_last  <= (s1_row == ROW_W'(lla_pkg::GRID_HEIGHT - 1)) &&
                   (s1_col == COL_W'(lla_pkg::GRID_WIDTH - 1));
    end
  end

  assign m_tdata = {3'b000, out_alive, out_col, out_row};
  assign m_tlast = out_last;

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> s1_valid)
    else $error("forwarded line data without an item in stage 1");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |-> !s_tready)
    else $error("cell accepted while stage 1 is held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten before it was taken");

  a_last_column: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[19:10] == IDX_W'(lla_pkg::GRID_WIDTH - 2)))
    else $error("frame end flagged away from the last interior column");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int MASK_W = lla_pkg::MASK_W;
  localparam int IDX_W = lla_pkg::IDX_W;
  localparam int CFG_IDX_W = lla_pkg::CFG_IDX_W;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int QUEUE_CAP = 4096;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD = 400;
  localparam int NUM_PHASES = 10;
  localparam int FIRST_RUN = 40;
  localparam int PHASE_RUN = 30;
  localparam int HOLD_RUN = 60;
  localparam int TAIL_RUN = 40;
  localparam logic [CFG_IDX_W-1:0] BAD_INDEX = '1;
  localparam logic [CFG_IDX_W-1:0] NEXT_INDEX = lla_pkg::REG_SURVIVE + 1'b1;

  typedef struct {
    bit alive;
    bit frame_start;
  } cell_t;

  typedef struct {
    bit [IDX_W-1:0] row;
    bit [IDX_W-1:0] col;
    bit alive_next;
    bit frame_end;
  } gen_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;   // [0] cell_alive
  logic s_tuser;         // [0] frame_start
  logic m_tvalid;
  logic m_tready;
  logic [23:0] m_tdata;  // [9:0] row_index, [19:10] col_index, [20] next_alive
  logic m_tlast;         // last_of_frame
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MASK_W-1:0] cfg_data;

  life_like_automaton_generation DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // generation predictor state
  bit upper_row [lla_pkg::GRID_WIDTH];
  bit middle_row [lla_pkg::GRID_WIDTH];
  bit [MASK_W-1:0] window_bits = '0;
  int row_pos = 0;
  int col_pos = 0;
  bit [MASK_W-1:0] birth_rule = lla_pkg::BIRTH_RESET;
  bit [MASK_W-1:0] survive_rule = lla_pkg::SURVIVE_RESET;

  cell_t cell_queue[$];
  gen_result_t expected_cells[$];
  cell_t cur_cell = '{0, 0};
  bit holding = 0;
  bit in_fire = 0;
  bit out_fire = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  bit ready_next;

  int errors = 0;
  int stall_cycles = 0;
  int cells_sent = 0;
  int results_checked = 0;
  int frame_ends = 0;
  int reg_writes = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic predict_cell(input cell_t item);
    int r;
    int c;
    int n;
    bit center;
    gen_result_t res;
    if (item.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (c >= lla_pkg::GRID_WIDTH) c = 0;
    window_bits = {item.alive, middle_row[c], upper_row[c], window_bits[8:3]};
    upper_row[c] = middle_row[c];
    middle_row[c] = item.alive;
    if (r >= 2 && c >= 2) begin
      center = window_bits[4];
      n = $countones(window_bits) - center;
      res.alive_next = center ? survive_rule[n] : birth_rule[n];
      res.row = IDX_W'(r - 1);
      res.col = IDX_W'(c - 1);
      res.frame_end = (r == lla_pkg::GRID_HEIGHT - 1) && (c == lla_pkg::GRID_WIDTH - 1);
      expected_cells.push_back(res);
    end
    c++;
    if (c >= lla_pkg::GRID_WIDTH) begin
      c = 0;
      r++;
      if (r >= lla_pkg::GRID_HEIGHT) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  function automatic void note_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  task automatic check_result();
    gen_result_t exp;
    if (expected_cells.size() == 0) begin
      note_mismatch($sformatf("unexpected result row %0d col %0d next %0d last %0d",
                              m_tdata[9:0], m_tdata[19:10], m_tdata[20], m_tlast));
    end else begin
      exp = expected_cells.pop_front();
      results_checked++;
      if (m_tlast) frame_ends++;
      if (m_tdata[9:0] !== exp.row || m_tdata[19:10] !== exp.col ||
          m_tdata[20] !== exp.alive_next || m_tlast !== exp.frame_end)
        note_mismatch($sformatf("exp row %0d col %0d next %0d last %0d, got %0d %0d %0d %0d",
                                exp.row, exp.col, exp.alive_next, exp.frame_end,
                                m_tdata[9:0], m_tdata[19:10], m_tdata[20], m_tlast));
    end
  endtask

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    in_fire = !rst && s_tvalid && s_tready;
    out_fire = !rst && m_tvalid && m_tready;
    if (out_fire) check_result();
    if (in_fire) begin
      predict_cell(cur_cell);
      cells_sent++;
    end
    if (in_fire || out_fire || (cfg_valid && cfg_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // cell driver
  always @(negedge clk) begin
    if (in_fire) holding = 0;
    if (!rst && !holding && cell_queue.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      cur_cell = cell_queue.pop_front();
      holding = 1;
    end
    s_tvalid <= holding;
    s_tdata <= {7'd0, cur_cell.alive};
    s_tuser <= cur_cell.frame_start;
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 0;
    end else begin
      ready_next = !rst && ($urandom_range(99) >= recv_stall_pct);
    end
    m_tready <= ready_next;
  end

  task automatic push_cell(input bit alive, input bit start);
    cell_t item;
    while (cell_queue.size() > QUEUE_CAP) @(posedge clk);
    item.alive = alive;
    item.frame_start = start;
    cell_queue.push_back(item);
  endtask

  task automatic send_cells(input int count, input int density);
    int i;
    for (i = 0; i < count; i++)
      push_cell($urandom_range(99) < density, 1'b0);
  endtask

  // rows 0..1 and the head of row 2: full block, empty block, ring around a
  // dead center, then random
  task automatic send_pattern_rows();
    int r;
    int c;
    bit alive;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < ((r < 2) ? lla_pkg::GRID_WIDTH : FIRST_RUN); c++) begin
        if (c < 10) alive = 1;
        else if (c < 20) alive = 0;
        else if (c < 23) alive = !(r == 1 && c == 21);
        else alive = $urandom_range(1);
        push_cell(alive, r == 0 && c == 0);
      end
    end
  endtask

  task automatic wait_idle();
    while (cell_queue.size() != 0 || holding || expected_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lla_pkg::REG_BIRTH) birth_rule = val;
    else if (idx == lla_pkg::REG_SURVIVE) survive_rule = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  initial begin
    int phase;
    logic [MASK_W-1:0] b;
    logic [MASK_W-1:0] s;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = 0;
    m_tready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // one grid carried across all phases; later phases extend row 2
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        wait_idle();
        case (phase)
          1: begin b = '1; s = '1; end
          2: begin b = '0; s = '0; end
          3: begin b = '1; s = '0; end
          4: begin b = '0; s = '1; end
          default: begin
            b = MASK_W'($urandom_range(511));
            s = MASK_W'($urandom_range(511));
          end
        endcase
        write_reg(lla_pkg::REG_BIRTH, b);
        write_reg(lla_pkg::REG_SURVIVE, s);
        if (phase == 4) begin
          write_reg(BAD_INDEX, MASK_W'($urandom_range(511)));
          write_reg(NEXT_INDEX, MASK_W'($urandom_range(511)));
        end
      end
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 45; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 45; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase

      if (phase == 0) send_pattern_rows();
      else send_cells((phase == 2) ? HOLD_RUN : PHASE_RUN, $urandom_range(5, 95));
      if (phase == 2) begin
        while (expected_cells.size() == 0) @(posedge clk);
        hold_requests++;
      end
    end

    wait_idle();
    // two frame starts in a row, then a short run on the top border row
    push_cell(1'b1, 1'b1);
    push_cell(1'b0, 1'b1);
    send_cells(TAIL_RUN, 50);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d cells and %0d checked results over %0d traffic phases",
             cells_sent, results_checked, NUM_PHASES);
    $display("including %0d grid ends and %0d rule register writes", frame_ends, reg_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lla_pkg.sv
rtl/core/lla_ram.sv
rtl/core/lla_rule.sv
rtl/core/life_like_automaton_generation.sv
test/tb.sv
